// ===== rtl/core/bre_pkg.sv =====
// Shared types, widths and helpers for the bitmap range engine.
// No dependencies; compiled first.
package bre_pkg;

  // Field widths of request and response
  localparam int unsigned OP_W      = 2;
  localparam int unsigned START_W   = 15;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned END_W     = 17;  // start + count, no overflow
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned BSEL_W    = 5;   // bit position inside a word
  localparam int unsigned DEF_NUM_WORDS = 1024;

  typedef enum logic [OP_W-1:0] {
    OP_TEST       = 2'd0,
    OP_TEST_CLEAR = 2'd1,
    OP_SET        = 2'd2,
    OP_CLEAR      = 2'd3
  } op_e;

  typedef logic [WORD_BITS-1:0] word_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;     // latch request, point read address at first word
    logic clear;    // sweep: zero one word, advance address
    logic issue;    // read next word of the range
    logic restart;  // rewind to first word for a second pass
    logic write;    // write back the modified word in stage 1
    logic emit;     // load the response register
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    op_e  op;
    logic err;         // range runs past the end
    logic zero;        // zero-length range
    logic sweep_last;  // sweep address at last word
    logic s1_vld;      // word data valid in stage 1
    logic s1_last;     // stage 1 holds the last word of the range
    logic s1_miss;     // stage 1 word has a range bit clear
    logic rsp_free;    // response register can take a new result
  } status_t;

  // Range bits inside one word; lo is the first bit, end_lo the end bit mod 32
  function automatic word_t word_mask(logic is_first, logic is_last,
                                      logic [BSEL_W-1:0] lo,
                                      logic [BSEL_W-1:0] end_lo);
    word_t full;
    word_t m;
    full = '1;
    m    = full;
    if (is_first) m = m & (full << lo);
    if (is_last)  m = m & (full >> (BSEL_W'(0) - end_lo));
    return m;
  endfunction

endpackage

// ===== rtl/core/bre_req_if.sv =====
// Request channel of the bitmap range engine: op, start bit, bit count.
// Depends on bre_pkg for field widths.
interface bre_req_if;
  logic                         valid;
  logic                         ready;
  logic [bre_pkg::OP_W-1:0]     op;
  logic [bre_pkg::START_W-1:0]  start_bit;
  logic [bre_pkg::COUNT_W-1:0]  bit_count;

  modport source (output valid, op, start_bit, bit_count, input ready);
  modport sink   (input valid, op, start_bit, bit_count, output ready);
endinterface

// ===== rtl/core/bre_rsp_if.sv =====
// Response channel of the bitmap range engine: all_set and range_error.
// No package dependency.
interface bre_rsp_if;
  logic valid;
  logic ready;
  logic all_set;
  logic range_error;

  modport source (output valid, all_set, range_error, input ready);
  modport sink   (input valid, all_set, range_error, output ready);
endinterface

// ===== rtl/core/bre_dp.sv =====
// Datapath of the bitmap range engine: request registers, bitmap memory,
// word walker with a registered read stage, and the response register.
// Depends on bre_pkg.
module bre_dp #(
  parameter int unsigned NUM_WORDS = bre_pkg::DEF_NUM_WORDS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [bre_pkg::OP_W-1:0]    op_i,
  input  logic [bre_pkg::START_W-1:0] start_bit_i,
  input  logic [bre_pkg::COUNT_W-1:0] bit_count_i,
  input  bre_pkg::cmd_t               cmd_i,
  output bre_pkg::status_t            status_o,
  input  logic                        rsp_ready_i,
  output logic                        rsp_valid_o,
  output logic                        all_set_o,
  output logic                        range_error_o
);
  import bre_pkg::*;

  localparam int unsigned AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned TOTAL_BITS = NUM_WORDS * WORD_BITS;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_WORDS - 1);

  // Request decode
  logic [END_W-1:0] end_bit;
  logic [END_W-1:0] end_m1;
  logic             req_err;
  logic             req_zero;
  logic [AW-1:0]    req_first_w;
  logic [AW-1:0]    req_last_w;

  assign end_bit     = END_W'(start_bit_i) + END_W'(bit_count_i);
  assign end_m1      = end_bit - END_W'(1);
  assign req_err     = 32'(end_bit) > TOTAL_BITS;
  assign req_zero    = (bit_count_i == '0);
  assign req_first_w = AW'(start_bit_i[START_W-1:BSEL_W]);
  assign req_last_w  = AW'(end_m1[END_W-1:BSEL_W]);

  // Latched request
  op_e               op_q;
  logic [AW-1:0]     first_w_q;
  logic [AW-1:0]     last_w_q;
  logic [BSEL_W-1:0] lo_q;
  logic [BSEL_W-1:0] end_lo_q;
  logic              err_q;
  logic              zero_q;

  // Walker and pipeline
  logic [AW-1:0] rd_addr_q;
  logic          issue_done_q;
  logic          s1_vld_q;
  logic [AW-1:0] s1_addr_q;
  word_t         rdata_q;
  logic          fail_q;

  // Response register
  logic rsp_valid_q;
  logic all_set_q;
  logic range_error_q;

  word_t mem_q [NUM_WORDS];

  // Stage 1 mask, check and update
  logic    is_first;
  logic    is_last;
  word_t   mask;
  logic    miss;
  word_t   upd;
  logic    do_issue;
  logic    mem_we;
  logic [AW-1:0] mem_waddr;
  word_t   mem_wdata;

  assign is_first  = (s1_addr_q == first_w_q);
  assign is_last   = (s1_addr_q == last_w_q);
  assign mask      = word_mask(is_first, is_last, lo_q, end_lo_q);
  assign miss      = ((rdata_q & mask) != mask);
  assign upd       = (op_q == OP_SET) ? (rdata_q | mask) : (rdata_q & ~mask);
  assign do_issue  = cmd_i.issue && !issue_done_q;
  assign mem_we    = cmd_i.clear || (cmd_i.write && s1_vld_q);
  assign mem_waddr = cmd_i.clear ? rd_addr_q : s1_addr_q;
  assign mem_wdata = cmd_i.clear ? '0 : upd;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q    <= '0;
      issue_done_q <= 1'b0;
      s1_vld_q     <= 1'b0;
      fail_q       <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        rd_addr_q    <= req_first_w;
        issue_done_q <= 1'b0;
      end else if (cmd_i.restart) begin
        rd_addr_q    <= first_w_q;
        issue_done_q <= 1'b0;
      end else if (cmd_i.clear) begin
        rd_addr_q <= rd_addr_q + AW'(1);
      end else if (do_issue) begin
        rd_addr_q    <= rd_addr_q + AW'(1);
        issue_done_q <= (rd_addr_q == last_w_q);
      end
      s1_vld_q <= do_issue;
      if (cmd_i.load) begin
        fail_q <= 1'b0;
      end else if (s1_vld_q && miss) begin
        fail_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= op_e'(op_i);
      first_w_q <= req_first_w;
      last_w_q  <= req_last_w;
      lo_q      <= start_bit_i[BSEL_W-1:0];
      end_lo_q  <= end_bit[BSEL_W-1:0];
      err_q     <= req_err;
      zero_q    <= req_zero;
    end
    if (do_issue) begin
      s1_addr_q <= rd_addr_q;
    end
    if (cmd_i.emit) begin
      all_set_q     <= !err_q && !fail_q;
      range_error_q <= err_q;
    end
  end

  // Bitmap memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (do_issue) begin
      rdata_q <= mem_q[rd_addr_q];
    end
  end

  assign status_o.op         = op_q;
  assign status_o.err        = err_q;
  assign status_o.zero       = zero_q;
  assign status_o.sweep_last = (rd_addr_q == LAST_ADDR);
  assign status_o.s1_vld     = s1_vld_q;
  assign status_o.s1_last    = s1_vld_q && is_last;
  assign status_o.s1_miss    = s1_vld_q && miss;
  assign status_o.rsp_free   = !rsp_valid_q || rsp_ready_i;

  assign rsp_valid_o   = rsp_valid_q;
  assign all_set_o     = all_set_q;
  assign range_error_o = range_error_q;

endmodule

// ===== rtl/core/bre_ctrl.sv =====
// Controller of the bitmap range engine: reset sweep, request dispatch,
// test pass, write pass and result hand-off. Depends on bre_pkg.
module bre_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  bre_pkg::status_t  status_i,
  output bre_pkg::cmd_t     cmd_o
);
  import bre_pkg::*;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DISPATCH,
    ST_TEST,
    ST_WRITE,
    ST_FINISH
  } state_e;

  state_e state_q;
  state_e state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_SWEEP: begin
        cmd_o.clear = 1'b1;
        if (status_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status_i.err || status_i.zero) begin
          state_d = ST_FINISH;
        end else if (status_i.op == OP_SET || status_i.op == OP_CLEAR) begin
          state_d = ST_WRITE;
        end else begin
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        cmd_o.issue = 1'b1;
        if (status_i.s1_miss) begin
          // early out: a clear bit decides the test
          state_d = ST_FINISH;
        end else if (status_i.s1_last) begin
          if (status_i.op == OP_TEST_CLEAR) begin
            cmd_o.issue   = 1'b0;
            cmd_o.restart = 1'b1;
            state_d       = ST_WRITE;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_WRITE: begin
        cmd_o.issue = 1'b1;
        cmd_o.write = 1'b1;
        if (status_i.s1_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.rsp_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);

endmodule

// ===== rtl/core/bitmap_range_engine.sv =====
// Top level of the bitmap range engine: controller, datapath, assertions.
// Depends on bre_pkg, bre_req_if, bre_rsp_if, bre_ctrl and bre_dp.
//
// Usage:
//   req_i carries one range request per transaction: op (test, test and
//   clear, set range, clear range), start_bit and bit_count. rsp_o returns
//   one transaction per request: all_set (range was fully set before the
//   operation) and range_error (range runs past the end; nothing changed).
//   A zero-length or out-of-range request goes straight to the result;
//   test, set and clear walk the 32-bit words that the range spans, and
//   a test and clear that finds all bits set walks them twice, a test
//   pass and then a write pass. A test stops at the first word with a
//   clear bit. The walk is set by the single read port of the bitmap
//   memory, one word per cycle. One request is in flight at a time; the
//   next one can be accepted in the cycle after the previous result is
//   loaded into the response register.
//   Reset: the bitmap is zeroed by a sweep over all NUM_WORDS words, one word
//   a cycle; req_i.ready stays low until it ends.
//   Stall: a finished result waits in the response register; a new request
//   is still accepted and processed, and holds at the end until rsp_o frees.
module bitmap_range_engine #(
  parameter int unsigned NUM_WORDS = bre_pkg::DEF_NUM_WORDS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bre_req_if.sink   req_i,
  bre_rsp_if.source rsp_o
);
  import bre_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    req_ready;

  bre_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bre_dp #(
    .NUM_WORDS (NUM_WORDS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (req_i.op),
    .start_bit_i   (req_i.start_bit),
    .bit_count_i   (req_i.bit_count),
    .cmd_i         (cmd),
    .status_o      (status),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_valid_o   (rsp_o.valid),
    .all_set_o     (rsp_o.all_set),
    .range_error_o (rsp_o.range_error)
  );

  assign req_i.ready = req_ready;

  // No request is taken while the bitmap is being zeroed
  a_no_accept_in_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |-> !req_ready)
    else $error("request accepted during reset sweep");

  // A bad or empty range never modifies the bitmap
  a_no_write_on_error : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.write && status.s1_vld) |-> (!status.err && !status.zero))
    else $error("bitmap written for an out-of-range or empty request");

  // A result handed to the response register is presented next cycle
  a_emit_presents : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> rsp_o.valid)
    else $error("response lost after emit");

  // An out-of-range result never reports all bits set
  a_error_not_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.range_error) |-> !rsp_o.all_set)
    else $error("range error reported together with all_set");

endmodule
